### hdl/census_transform_5x5_assert.svh
// ============================================================================
// census_transform_5x5_assert.svh
// Assertion macros used by the census transform checker.
// ============================================================================
`ifndef CENSUS_TRANSFORM_5X5_ASSERT_SVH
`define CENSUS_TRANSFORM_5X5_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("census transform check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("census transform check failed");

`endif

### hdl/ctf_pkg.sv
// ============================================================================
// ctf_pkg
// Types, constants and the census compare function of the census transform.
// ============================================================================
package ctf_pkg;

    // Field widths.
    localparam int PIX_W = 16;
    localparam int SIG_W = 32;
    localparam int CFG_W = 12;
    localparam int CNT_W = 14;

    // Line store word: one sample of each of the four delayed lines.
    localparam int LINES       = 4;
    localparam int LINE_WORD_W = LINES * PIX_W;

    // Window geometry.
    localparam int WIN_DIM = 5;
    localparam int TAPS    = WIN_DIM * WIN_DIM;
    localparam int CENTER  = 12;

    // Signature layout: the first neighbors fill the low byte from bit 7 down,
    // the rest fill the upper half from bit 31 down.
    localparam int LOW_NEIGHBORS = 8;
    localparam int LOW_TOP_BIT   = 7;
    localparam int HIGH_TOP_BIT  = 31 + LOW_NEIGHBORS;

    // Width register limits.
    localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd768;
    localparam logic [CFG_W-1:0] WIDTH_MIN   = 12'd5;

    // Result queue depth.
    localparam int QUEUE_DEPTH = 4;

    typedef logic [PIX_W-1:0] t_pixel;
    typedef t_pixel t_taps [TAPS];

    // Control that travels with an item from the front stage to the window.
    typedef struct packed {
        logic valid;
        logic emit;
        logic bypass;
    } t_s1_ctrl;

    // Census signature of a window: a bit is set when the neighbor is below
    // the center sample.
    function automatic logic [SIG_W-1:0] census_sig(input t_taps taps);
        logic [SIG_W-1:0] sig;
        int               k;
        sig = '0;
        k   = 0;
        for (int t = 0; t < TAPS; t++) begin
            if (t != CENTER) begin
                if (taps[t] < taps[CENTER]) begin
                    if (k < LOW_NEIGHBORS) begin
                        sig[LOW_TOP_BIT - k] = 1'b1;
                    end else begin
                        sig[HIGH_TOP_BIT - k] = 1'b1;
                    end
                end
                k++;
            end
        end
        return sig;
    endfunction

endpackage

### hdl/ctf_ram.sv
// ============================================================================
// ctf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module ctf_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 2048,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; a read at the address being written returns old data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ctf_front.sv
// ============================================================================
// ctf_front
// Input stage: width register, pixel counter, column, result classification
// and the line store read.
// ============================================================================
module ctf_front
    import ctf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    input  t_pixel           i_pixel,
    input  logic             i_frame_start,
    input  logic             i_hold,
    output logic             o_stall,
    output logic             o_rd_en,
    output logic [COL_W-1:0] o_rd_addr,
    output t_s1_ctrl         o_s1,
    output t_pixel           o_s1_pixel,
    output logic [COL_W-1:0] o_s1_col
);

    logic [CFG_W-1:0] r_width;
    logic [COL_W-1:0] r_column;
    logic [COL_W-1:0] n_column;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_s1_ctrl         r_s1;
    t_pixel           r_s1_pixel;
    logic [COL_W-1:0] r_s1_col;

    logic             accept;
    logic [CFG_W-1:0] eff_width;
    logic [CNT_W:0]   threshold;
    logic [COL_W-1:0] col_now;
    logic [CNT_W-1:0] cnt_now;
    logic [13:0]      col_inc;
    logic             emit;
    logic             bypass;

    // Width register; the user writes it only while the block is idle, unenforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    // Clamp the programmed width to the supported range.
    always_comb begin
        if (r_width < WIDTH_MIN) begin
            eff_width = WIDTH_MIN;
        end else if (int'(r_width) > MAX_WIDTH) begin
            eff_width = CFG_W'(MAX_WIDTH);
        end else begin
            eff_width = r_width;
        end
    end

    // A word is taken whenever the result queue has room for it.
    assign accept  = i_valid && !i_hold;
    assign o_stall = i_hold;

    // Counter and column restart with the first pixel of a frame.
    always_comb begin
        threshold = {1'b0, eff_width, 2'b00} + (CNT_W + 1)'(4);
        col_now   = i_frame_start ? '0 : r_column;
        cnt_now   = i_frame_start ? '0 : r_count;
        emit      = ({1'b0, cnt_now} >= threshold);
        col_inc   = 14'(col_now) + 14'd1;
        n_column  = (col_inc >= {2'b00, eff_width}) ? '0 : col_inc[COL_W-1:0];
        n_count   = emit ? cnt_now : cnt_now + CNT_W'(1);
        // The item in the window stage writes this column only at the coming edge.
        bypass    = r_s1.valid && (r_s1_col == col_now);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_count  <= '0;
        end else if (accept) begin
            r_column <= n_column;
            r_count  <= n_count;
        end
    end

    // Stage register toward the window; it never stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1.valid  <= accept;
            r_s1.emit   <= emit;
            r_s1.bypass <= bypass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= col_now;
        end
    end

    assign o_rd_en    = accept;
    assign o_rd_addr  = col_now;
    assign o_s1       = r_s1;
    assign o_s1_pixel = r_s1_pixel;
    assign o_s1_col   = r_s1_col;

endmodule

### hdl/ctf_window.sv
// ============================================================================
// ctf_window
// Back stage: line store update, 5x5 tap window and census compare.
// ============================================================================
module ctf_window
    import ctf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                   i_clk,
    input  t_s1_ctrl               i_s1,
    input  t_pixel                 i_s1_pixel,
    input  logic [COL_W-1:0]       i_s1_col,
    input  logic [LINE_WORD_W-1:0] i_rd_data,
    output logic                   o_wr_en,
    output logic [COL_W-1:0]       o_wr_addr,
    output logic [LINE_WORD_W-1:0] o_wr_data,
    output logic                   o_push,
    output logic [SIG_W-1:0]       o_push_sig
);

    t_taps                  r_taps;
    t_taps                  n_taps;
    logic [LINE_WORD_W-1:0] r_last_word;
    logic [LINE_WORD_W-1:0] old_word;
    logic [LINE_WORD_W-1:0] n_word;
    t_pixel                 feed [WIN_DIM];

    // Delayed samples of this column; the last written word covers a read
    // that raced the write to the same column.
    always_comb begin
        old_word = i_s1.bypass ? r_last_word : i_rd_data;
        n_word   = {old_word[LINE_WORD_W-PIX_W-1:0], i_s1_pixel};
        for (int r = 0; r < LINES; r++) begin
            feed[r] = old_word[PIX_W*(LINES-1-r) +: PIX_W];
        end
        feed[LINES] = i_s1_pixel;
    end

    // Each window row shifts left by one and takes its feed on the right.
    always_comb begin
        for (int r = 0; r < WIN_DIM; r++) begin
            for (int c = 0; c < WIN_DIM - 1; c++) begin
                n_taps[r*WIN_DIM + c] = r_taps[r*WIN_DIM + c + 1];
            end
            n_taps[r*WIN_DIM + WIN_DIM - 1] = feed[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1.valid) begin
            r_taps      <= n_taps;
            r_last_word <= n_word;
        end
    end

    assign o_wr_en    = i_s1.valid;
    assign o_wr_addr  = i_s1_col;
    assign o_wr_data  = n_word;
    assign o_push     = i_s1.valid && i_s1.emit;
    assign o_push_sig = census_sig(n_taps);

endmodule

### hdl/ctf_queue.sv
// ============================================================================
// ctf_queue
// Result queue between the census stage and the output channel.
// ============================================================================
module ctf_queue
    import ctf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [SIG_W-1:0] i_push_sig,
    input  logic             i_inflight,
    output logic             o_hold,
    output logic             o_valid,
    output logic [SIG_W-1:0] o_signature,
    input  logic             i_stall
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [SIG_W-1:0] r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;
    logic             pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_level != '0);

    // Hold the input while the queue cannot take the word still in flight.
    assign o_hold = ({1'b0, r_level} + (LVL_W + 1)'(i_inflight)) >= (LVL_W + 1)'(QUEUE_DEPTH);

    always_comb begin
        n_level = r_level;
        if (i_push && !pop) begin
            n_level = r_level + LVL_W'(1);
        end else if (!i_push && pop) begin
            n_level = r_level - LVL_W'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + PTR_W'(1);
            end
            if (pop) begin
                r_head <= r_head + PTR_W'(1);
            end
            r_level <= n_level;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_tail] <= i_push_sig;
        end
    end

    assign o_signature = r_entry[r_head];

endmodule

### hdl/census_transform_5x5.sv
// ============================================================================
// census_transform_5x5
// Streaming 5x5 census transform of 16-bit raster pixels.
// ============================================================================
// Pixels enter on i_valid / o_stall, one word per cycle, in raster order;
// i_frame_start marks the first pixel of a frame and restarts the pixel
// counter and the line column. Once 4*W+4 pixels of a frame have arrived,
// every accepted pixel yields one 32-bit signature on o_valid / i_stall: the
// census of the pixel two lines and two columns back, with windows wrapping
// across line ends. The width W is written through i_cfg_we / i_cfg_wdata
// only while the block is idle, a rule for the user that the block does not
// enforce, and is clamped to 5..MAX_WIDTH. An accepted pixel is registered
// with its line store read, then shifted into the window and compared.
// Throughput is one pixel per cycle, set by the line store, whose word of four
// delayed samples is read on one port and rewritten on the other per pixel.
// A four-entry result queue takes signatures while the receiver stalls;
// o_stall rises once the queue and the word in the compare stage fill it.
// Reset sets W to 768, clears the counter, the column and the queue; the line
// store is not cleared and needs no clearing pass.
// ============================================================================
module census_transform_5x5
    import ctf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_frame_start,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [SIG_W-1:0] o_signature
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                   hold;
    logic                   rd_en;
    logic [COL_W-1:0]       rd_addr;
    logic [LINE_WORD_W-1:0] rd_data;
    logic                   wr_en;
    logic [COL_W-1:0]       wr_addr;
    logic [LINE_WORD_W-1:0] wr_data;
    t_s1_ctrl               s1;
    t_pixel                 s1_pixel;
    logic [COL_W-1:0]       s1_col;
    logic                   push;
    logic [SIG_W-1:0]       push_sig;

    // Front: accept, count and classify, read the line store.
    ctf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_hold        (hold),
        .o_stall       (o_stall),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_s1          (s1),
        .o_s1_pixel    (s1_pixel),
        .o_s1_col      (s1_col)
    );

    // Line store: four delayed lines packed into one word per column.
    ctf_ram #(
        .DATA_W (LINE_WORD_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Back: window shift and census compare.
    ctf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_s1       (s1),
        .i_s1_pixel (s1_pixel),
        .i_s1_col   (s1_col),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_push     (push),
        .o_push_sig (push_sig)
    );

    // Result queue feeding the output channel.
    ctf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_sig  (push_sig),
        .i_inflight  (s1.valid && s1.emit),
        .o_hold      (hold),
        .o_valid     (o_valid),
        .o_signature (o_signature),
        .i_stall     (i_stall)
    );

endmodule

### hdl/ctf_checker.sv
// ============================================================================
// ctf_checker
// Port-level assertions for the census transform, bound to the top level.
// ============================================================================
`include "census_transform_5x5_assert.svh"

module ctf_checker
    import ctf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [SIG_W-1:0] o_signature
);

    // A stalled result word stays offered.
    `CTF_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // A stalled result word keeps its value.
    `CTF_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_valid && i_stall, $stable(o_signature))

    // The middle byte of a signature is never used.
    `CTF_ASSERT_NOW(a_mid_byte_zero, i_clk, i_rst_n, o_valid, o_signature[15:8] == 8'd0)

    // A result appears only after a pixel has passed the front stage register.
    `CTF_ASSERT_NOW(a_result_needs_pixel, i_clk, i_rst_n, $rose(o_valid), $past(i_valid && !o_stall, 2))

endmodule

bind census_transform_5x5 ctf_checker u_checker (.*);

### test/tb_census_transform_5x5.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_census_transform_5x5
// Self-checking testbench for the streaming 5x5 census transform.
// ============================================================================
// A scoreboard class tracks the line delays, the tap window and the pixel
// counter of the block, and predicts one signature for every accepted pixel
// once a frame is deep enough. Each signature word leaving the block is
// compared with the oldest prediction. The run starts at the reset width,
// then covers a directed frame of extreme pixel values at the narrowest
// width, a long frame at a medium width with neither side idling, a clamped
// width, and many random frames at small widths. Some frames are cut short,
// and both sides of the block idle at random.
// ============================================================================
module tb_census_transform_5x5;
    import ctf_pkg::*;

    localparam int    TB_MAX_WIDTH  = 2048;
    localparam int    LONG_WIDTH    = 64;
    localparam int    RANDOM_PIXELS = 1140;
    localparam int    DRAIN_CYCLES  = 8;
    localparam time   TIMEOUT_NS    = 5_000_000;

    // Predicts the census signatures that the block produces.
    class census_predictor;
        t_pixel           line_mem [LINES][TB_MAX_WIDTH];
        t_taps            window;
        int unsigned      frame_count;
        int unsigned      column;
        logic [CFG_W-1:0] width_reg;
        logic [SIG_W-1:0] pending_signatures [$];
        int unsigned      errors;
        int unsigned      checked;

        function new();
            foreach (line_mem[r, c]) line_mem[r][c] = '0;
            foreach (window[t]) window[t] = '0;
            frame_count = 0;
            column      = 0;
            width_reg   = WIDTH_RESET;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_width(logic [CFG_W-1:0] value);
            width_reg = value;
        endfunction

        // Line width in use, with the register clamped to the legal range.
        function int unsigned line_width();
            int unsigned w;
            w = width_reg;
            if (w < WIDTH_MIN) w = WIDTH_MIN;
            if (w > TB_MAX_WIDTH) w = TB_MAX_WIDTH;
            return w;
        endfunction

        // A bit is set when the neighbor is strictly below the center tap.
        function logic [SIG_W-1:0] census_word();
            logic [SIG_W-1:0] sig;
            int               k;
            sig = '0;
            k   = 0;
            for (int t = 0; t < TAPS; t++) begin
                if (t != CENTER) begin
                    if (window[t] < window[CENTER]) begin
                        if (k < 8) begin
                            sig[7 - k] = 1'b1;
                        end else begin
                            sig[39 - k] = 1'b1;
                        end
                    end
                    k++;
                end
            end
            return sig;
        endfunction

        // Called for every pixel word the block accepts.
        function void note_pixel(t_pixel px, logic fs);
            int unsigned w;
            int unsigned thr;
            int unsigned c;
            t_pixel      feed [WIN_DIM];
            w   = line_width();
            thr = 4 * w + 4;
            if (fs) begin
                frame_count = 0;
                column      = 0;
            end
            c = (column >= TB_MAX_WIDTH) ? 0 : column;

            // Bottom row takes the new pixel; the rows above come from the
            // delay lines, oldest line on top.
            feed[WIN_DIM-1] = px;
            for (int r = 0; r < LINES; r++) feed[LINES-1-r] = line_mem[r][c];
            line_mem[0][c] = px;
            for (int r = 1; r < LINES; r++) line_mem[r][c] = feed[LINES-r];

            // Shift every window row left by one and append the new column.
            for (int r = 0; r < WIN_DIM; r++) begin
                for (int k = 0; k < WIN_DIM-1; k++) begin
                    window[r*WIN_DIM + k] = window[r*WIN_DIM + k + 1];
                end
                window[r*WIN_DIM + WIN_DIM-1] = feed[r];
            end

            column = (c + 1 >= w) ? 0 : c + 1;
            if (frame_count >= thr) begin
                pending_signatures.push_back(census_word());
            end else begin
                frame_count++;
            end
        endfunction

        function int pending();
            return pending_signatures.size();
        endfunction

        function void check_signature(logic [SIG_W-1:0] got);
            logic [SIG_W-1:0] want;
            if (pending_signatures.size() == 0) begin
                $error("signature: expected none pending, actual %h", got);
                errors++;
                return;
            end
            want = pending_signatures.pop_front();
            checked++;
            if (got !== want) begin
                $error("signature: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_valid;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel;
    logic             i_frame_start;
    logic             o_valid;
    logic             i_stall;
    logic [SIG_W-1:0] o_signature;

    census_predictor sb;
    bit              gaps_on;
    bit              stalls_on;
    int              stall_left;
    int unsigned     pixels_sent;
    int unsigned     frames_sent;
    int unsigned     widths_written;

    census_transform_5x5 #(
        .MAX_WIDTH(TB_MAX_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .i_frame_start(i_frame_start),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_signature  (o_signature)
    );

    // 50 MHz clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver stalls come in short random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall    = 1'b1;
        end else if (stalls_on && $urandom_range(69) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_stall    = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    // Every signature word taken from the block is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            sb.check_signature(o_signature);
        end
    end

    // Pixel source for a frame: full range, a narrow range with many equal
    // values, the extremes, or a fixed cycle of extremes for directed tests.
    function automatic t_pixel pick_pixel(int mode, int idx);
        int sel;
        sel = (mode == 3) ? idx % 7 : $urandom_range(0, 5);
        case (mode)
            0: return t_pixel'($urandom);
            1: return t_pixel'($urandom_range(0, 3));
            default: begin
                case (sel)
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return 16'h8000;
                    3: return 16'h7FFF;
                    4: return 16'h0001;
                    5: return 16'hFFFE;
                    default: return 16'h8000;
                endcase
            end
        endcase
    endfunction

    // Offers one pixel word and waits until the block takes it.
    task automatic send_pixel(input t_pixel px, input logic fs);
        int gap;
        if (gaps_on && $urandom_range(99) < 3) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_valid       = 1'b0;
            i_frame_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_pixel       = px;
        i_frame_start = fs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_pixel(px, fs);
        pixels_sent++;
    endtask

    // Stops sending and waits until every predicted signature has arrived.
    task automatic pause_until_drained();
        @(negedge i_clk);
        i_valid       = 1'b0;
        i_frame_start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] value);
        pause_until_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_width(value);
        widths_written++;
    endtask

    // Sends one frame; a negative pause index means no pause inside it.
    task automatic send_frame(input int len, input int mode, input bit first_fs,
                              input int pause_at);
        for (int i = 0; i < len; i++) begin
            if (i == pause_at && i > 0) pause_until_drained();
            send_pixel(pick_pixel(mode, i), first_fs && i == 0);
        end
        frames_sent++;
    endtask

    initial begin
        int               random_pixels;
        int               sel;
        int               w;
        int               thr;
        int               nframes;
        int               len;
        int               pause_at;
        logic [CFG_W-1:0] wv;

        sb             = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_valid        = 1'b0;
        i_pixel        = '0;
        i_frame_start  = 1'b0;
        i_stall        = 1'b0;
        stall_left     = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        pixels_sent    = 0;
        frames_sent    = 0;
        widths_written = 0;
        random_pixels  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset width, and a short first frame without a frame start marker:
        // the cleared counter keeps it below the threshold, so no signature
        // is due.
        send_frame(24, 0, 1'b0, -1);

        // A width below the minimum clamps to five. The directed frame walks a
        // cycle of extreme values, so windows see equal neighbors, an all-zero
        // center and an all-ones center; the sender pauses near its end.
        write_width(12'd0);
        send_frame(32, 3, 1'b1, 28);
        // A frame cut short by a new frame start.
        send_frame(10, 2, 1'b1, -1);
        send_frame(30, 2, 1'b1, -1);

        // A long line, with neither side idling.
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_width(CFG_W'(LONG_WIDTH));
        send_frame(4 * LONG_WIDTH + 4 + 16, 0, 1'b1, -1);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // An all-ones width clamps to the widest line: no signature is due.
        write_width(12'hFFF);
        send_frame(40, 0, 1'b1, -1);

        // Random widths, mostly small, each followed by a few frames.
        while (random_pixels < RANDOM_PIXELS) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                wv = CFG_W'($urandom_range(5, 12));
            end else if (sel < 85) begin
                wv = CFG_W'($urandom_range(0, 4));
            end else begin
                wv = CFG_W'($urandom_range(13, 48));
            end
            write_width(wv);
            w       = (wv < WIDTH_MIN) ? WIDTH_MIN : wv;
            thr     = 4 * w + 4;
            nframes = $urandom_range(1, 4);
            for (int f = 0; f < nframes && random_pixels < RANDOM_PIXELS; f++) begin
                if ($urandom_range(99) < 15) begin
                    len = $urandom_range(1, thr - 1);
                end else begin
                    len = thr + $urandom_range(1, 3 * w);
                end
                // The last frame is trimmed to the pixel budget.
                if (len > RANDOM_PIXELS - random_pixels) begin
                    len = RANDOM_PIXELS - random_pixels;
                end
                pause_at = ($urandom_range(9) == 0) ? $urandom_range(0, len - 1) : -1;
                send_frame(len, $urandom_range(0, 2), 1'b1, pause_at);
                random_pixels += len;
            end
        end

        pause_until_drained();
        $display("Covered %0d pixels in %0d frames over %0d width settings;",
                 pixels_sent, frames_sent, widths_written);
        $display("%0d signatures were checked against the prediction.", sb.checked);
        if (sb.errors == 0) begin
            $display("** census_transform_5x5: PASSED **");
        end else begin
            $display("** census_transform_5x5: FAILED **");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d signatures still pending.", sb.pending());
        $display("** census_transform_5x5: FAILED **");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ctf_pkg.sv
hdl/ctf_ram.sv
hdl/ctf_front.sv
hdl/ctf_window.sv
hdl/ctf_queue.sv
hdl/census_transform_5x5.sv
hdl/ctf_checker.sv
test/tb_census_transform_5x5.sv
